// ===== rtl/integer_to_ascii_digits_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the integer to ASCII digits converter
// Clocked on aclk and disabled while aresetn is low.
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_DIGITS_ASSERT_SVH
`define INTEGER_TO_ASCII_DIGITS_ASSERT_SVH

// Same-cycle implication.
`define ITAD_ASSERT_IMPLIES(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ITAD_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (cons)) else $error(msg);

`endif

// ===== rtl/itad_pkg.sv =====
// ---------------------------------------------------------------------------
// itad_pkg
// Word types, mode codes and character constants of the integer to ASCII
// digits converter.
// ---------------------------------------------------------------------------
package itad_pkg;

    typedef struct packed {
        logic [63:0] value;
        logic [1:0]  mode;
    } in_word_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_char;
    } out_word_t;

    localparam logic [1:0] MODE_HEX  = 2'd0;
    localparam logic [1:0] MODE_UDEC = 2'd1;
    localparam logic [1:0] MODE_SDEC = 2'd2;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_H     = 8'h48;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // Upper-case glyph of one hexadecimal or decimal digit.
    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        if (d < 4'd10) begin
            g = CHAR_ZERO + {4'd0, d};
        end else begin
            g = CHAR_A + {4'd0, d} - 8'd10;
        end
        return g;
    endfunction

endpackage

// ===== rtl/integer_to_ascii_digits.sv =====
// ---------------------------------------------------------------------------
// integer_to_ascii_digits
// Converts one number per word into its ASCII text, hexadecimal with an H
// suffix, unsigned decimal or signed decimal, one character per output word.
// ---------------------------------------------------------------------------
// Channel   Direction  Word        Contents
// s_        in         in_word_t   value, mode
// m_        out        out_word_t  char_out, last_char
//
// A decimal word is shifted through the shift-and-add-3 converter, one bit
// per cycle, then a negative one sends a minus sign; leading zero digits are
// skipped, then the digits go out one per word; a hexadecimal word goes straight
// to the digit shifter. A word is taken only while the converter is idle;
// mode 3 is dropped. Characters wait in the output register while m_ready
// is low. Reset is synchronous on aresetn and leaves the block idle.
// ---------------------------------------------------------------------------
module integer_to_ascii_digits
    import itad_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam int NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;
    localparam int BW   = 4 * NDIG;
    localparam int CW   = $clog2(VALUE_WIDTH + 1);
    localparam int RW   = $clog2(NDIG + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CONV   = 3'd1;
    localparam logic [2:0] S_SIGN   = 3'd2;
    localparam logic [2:0] S_SKIP   = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_SUFFIX = 3'd5;

    logic [2:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] bin_reg, bin_next;
    logic [BW-1:0]          bcd_reg, bcd_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic                   neg_reg, neg_next;
    logic                   hex_reg, hex_next;
    logic                   m_valid_reg, m_valid_next;
    out_word_t              m_data_reg, m_data_next;

    logic [VALUE_WIDTH-1:0] in_v;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [BW-1:0]          dab;
    logic [3:0]             top_digit;
    logic                   out_free;
    logic                   digit_phase;
    logic                   dec_phase;
    logic                   minus_out;
    logic                   suffix_go;
    logic                   suffix_out;

    assign in_v      = s_data.value[VALUE_WIDTH-1:0];
    assign in_neg    = (s_data.mode == MODE_SDEC) && in_v[VALUE_WIDTH-1];
    assign in_mag    = in_neg ? (~in_v + VALUE_WIDTH'(1)) : in_v;
    assign top_digit = bcd_reg[BW-1 -: 4];
    assign out_free  = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        dab = bcd_reg;
        for (int i = 0; i < NDIG; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                dab[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        bin_next     = bin_reg;
        bcd_next     = bcd_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        neg_next     = neg_reg;
        hex_next     = hex_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    bin_next = in_mag;
                    neg_next = in_neg;
                    rem_next = RW'(NDIG);
                    cnt_next = CW'(VALUE_WIDTH);
                    if (s_data.mode == MODE_HEX) begin
                        hex_next   = 1'b1;
                        bcd_next   = {{(BW - VALUE_WIDTH){1'b0}}, in_v};
                        state_next = S_SKIP;
                    end else if (s_data.mode == MODE_UDEC || s_data.mode == MODE_SDEC) begin
                        hex_next   = 1'b0;
                        bcd_next   = '0;
                        state_next = S_CONV;
                    end
                end
            end
            S_CONV: begin
                bcd_next = {dab[BW-2:0], bin_reg[VALUE_WIDTH-1]};
                bin_next = {bin_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = neg_reg ? S_SIGN : S_SKIP;
                end
            end
            S_SIGN: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.char_out  = CHAR_MINUS;
                    m_data_next.last_char = 1'b0;
                    state_next            = S_SKIP;
                end
            end
            S_SKIP: begin
                if (top_digit == 4'd0 && rem_reg != RW'(1)) begin
                    bcd_next = {bcd_reg[BW-5:0], 4'd0};
                    rem_next = rem_reg - RW'(1);
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.char_out  = digit_glyph(top_digit);
                    m_data_next.last_char = (rem_reg == RW'(1)) && !hex_reg;
                    bcd_next              = {bcd_reg[BW-5:0], 4'd0};
                    rem_next              = rem_reg - RW'(1);
                    if (rem_reg == RW'(1)) begin
                        state_next = hex_reg ? S_SUFFIX : S_IDLE;
                    end
                end
            end
            S_SUFFIX: begin
                if (out_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.char_out  = CHAR_H;
                    m_data_next.last_char = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        bin_reg    <= bin_next;
        bcd_reg    <= bcd_next;
        cnt_reg    <= cnt_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        hex_reg    <= hex_next;
        m_data_reg <= m_data_next;
    end

    assign digit_phase = (state_reg == S_SKIP) || (state_reg == S_EMIT);
    assign dec_phase   = digit_phase && !hex_reg;
    assign minus_out   = m_valid_reg && (m_data_reg.char_out == CHAR_MINUS);
    assign suffix_go   = (state_reg == S_SUFFIX) && out_free;
    assign suffix_out  = m_valid_reg && m_data_reg.last_char && (m_data_reg.char_out == CHAR_H);

`include "integer_to_ascii_digits_assert.svh"

    `ITAD_ASSERT_IMPLIES(a_rem_nonzero, digit_phase, rem_reg != '0, "digit count ran out")
    `ITAD_ASSERT_IMPLIES(a_bcd_digit, dec_phase, top_digit <= 4'd9, "decimal digit above nine")
    `ITAD_ASSERT_IMPLIES(a_minus_not_last, minus_out, !m_data_reg.last_char, "sign marked as last")
    `ITAD_ASSERT_NEXT(a_suffix_last, suffix_go, suffix_out, "suffix not sent last")

endmodule

// ===== bench/integer_to_ascii_digits_check.sv =====
// ---------------------------------------------------------------------------
// integer_to_ascii_digits_check
// Watches both channels of the converter. Every accepted input word but a
// mode 3 one is spelt out here as the expected character words, which are
// compared field by field with the output words as they are accepted.
// ---------------------------------------------------------------------------
module integer_to_ascii_digits_check
    import itad_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  in_word_t  s_data,
    input  logic      m_valid,
    input  logic      m_ready,
    input  out_word_t m_data,
    output int        fail_count,
    output int        chars_pending
);

    localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH);

    out_word_t expected_chars[$];
    int        mismatches = 0;

    task automatic report_mismatch(input string what);
        $display("%0t: %s", $time, what);
        mismatches++;
    endtask

    function automatic void spell_number(input in_word_t w);
        bit [63:0] mag;
        bit [63:0] base;
        bit [63:0] rem;
        bit [7:0]  digit;
        bit [7:0]  digits[$];
        bit [7:0]  text[$];
        out_word_t c;
        mag = w.value & VALUE_MASK;
        case (w.mode)
            MODE_HEX: begin
                base = 64'd16;
            end
            MODE_UDEC: begin
                base = 64'd10;
            end
            MODE_SDEC: begin
                base = 64'd10;
                if (mag[VALUE_WIDTH-1]) begin
                    text.push_back(CHAR_MINUS);
                    mag = (~mag + 64'd1) & VALUE_MASK;
                end
            end
            default: begin
                return;
            end
        endcase
        do begin
            rem = mag % base;
            digit = rem[7:0];
            digits.push_front((digit < 8'd10) ? CHAR_ZERO + digit : CHAR_A + digit - 8'd10);
            mag = mag / base;
        end while (mag != 64'd0);
        foreach (digits[i]) begin
            text.push_back(digits[i]);
        end
        if (w.mode == MODE_HEX) begin
            text.push_back(CHAR_H);
        end
        foreach (text[i]) begin
            c.char_out = text[i];
            c.last_char = (i == text.size() - 1);
            expected_chars.push_back(c);
        end
    endfunction

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                spell_number(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("character word 0x%02h with nothing expected",
                                              m_data.char_out));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.char_out !== want.char_out) begin
                        report_mismatch($sformatf("char_out 0x%02h, expected 0x%02h",
                                                  m_data.char_out, want.char_out));
                    end
                    if (m_data.last_char !== want.last_char) begin
                        report_mismatch($sformatf("last_char %b, expected %b on 0x%02h",
                                                  m_data.last_char, want.last_char,
                                                  want.char_out));
                    end
                end
            end
            chars_pending <= expected_chars.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== bench/integer_to_ascii_digits_test.sv =====
// ---------------------------------------------------------------------------
// integer_to_ascii_digits_test
// Drives the converter with directed corner values in every mode and then
// with several hundred random words in bursts, against a receiver that
// stalls in changing patterns and once holds off for a long stretch. The
// checker beside the block predicts and compares every character word.
// ---------------------------------------------------------------------------
module integer_to_ascii_digits_test;
    import itad_pkg::*;

    localparam int RANDOM_WORDS = 340;
    localparam int LONG_HOLD    = 700;
    localparam int SETTLE       = 200;

    typedef enum int {
        STALL_NONE,
        STALL_COIN,
        STALL_SPARSE,
        STALL_RARE
    } stall_style_e;

    localparam logic [1:0] MODE_DROP = 2'd3;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_word_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_word_t m_data;
    logic      hold_req;
    int        fail_count;
    int        chars_pending;

    integer_to_ascii_digits #(
        .VALUE_WIDTH(64)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    integer_to_ascii_digits_check #(
        .VALUE_WIDTH(64)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .chars_pending (chars_pending)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        #8000000;
        $display("FAIL");
        $finish;
    end

    function automatic in_word_t make_word(input logic [63:0] value, input logic [1:0] mode);
        in_word_t w;
        w.value = value;
        w.mode = mode;
        return w;
    endfunction

    function automatic logic [63:0] random_value();
        logic [63:0] v;
        logic [63:0] p;
        int          k;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            3: begin
                v = 64'($urandom_range(0, 99));
            end
            4, 8, 9: begin
                v = v >> $urandom_range(0, 63);
            end
            5: begin
                p = 64'd1;
                k = $urandom_range(0, 19);
                repeat (k) p = p * 64'd10;
                v = p + 64'($urandom_range(0, 2)) - 64'd1;
            end
            6: begin
                v = 64'd0 - 64'($urandom_range(1, 1000));
            end
            7: begin
                v = $urandom_range(0, 1) ? {1'b1, 63'd0} + 64'($urandom_range(0, 3))
                                         : {64{1'b1}} - 64'($urandom_range(0, 3));
            end
            default: begin
            end
        endcase
        return v;
    endfunction

    function automatic logic [1:0] random_mode();
        int pick;
        pick = $urandom_range(0, 15);
        return (pick == 0) ? MODE_DROP : 2'(pick % 3);
    endfunction

    task automatic send_word(input in_word_t w);
        s_valid <= 1'b1;
        s_data <= w;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic pause_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(posedge aclk);
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (chars_pending != 0);
    endtask

    // Receiver: stall patterns picked at random in turn, and one
    // long hold-off when the sender asks for it.
    initial begin
        stall_style_e style;
        int           style_left;
        int           hold_left;
        int           phase;
        logic         hold_seen;
        m_ready = 1'b0;
        style = STALL_NONE;
        style_left = 0;
        hold_left = 0;
        phase = 0;
        hold_seen = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            phase = (phase + 1) % 4;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                if (style_left == 0) begin
                    style = stall_style_e'($urandom_range(0, 3));
                    style_left = $urandom_range(20, 200);
                end
                style_left--;
                case (style)
                    STALL_NONE: begin
                        m_ready <= 1'b1;
                    end
                    STALL_COIN: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    STALL_SPARSE: begin
                        m_ready <= (phase == 0);
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 9) != 0);
                    end
                endcase
            end
        end
    end

    initial begin
        in_word_t corner_words[$];
        int       sent;
        int       burst;
        logic     drained;
        in_word_t w;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        hold_req = 1'b0;
        sent = 0;
        drained = 1'b0;

        corner_words.push_back(make_word(64'd0, MODE_HEX));
        corner_words.push_back(make_word(64'd0, MODE_UDEC));
        corner_words.push_back(make_word(64'd0, MODE_SDEC));
        corner_words.push_back(make_word({64{1'b1}}, MODE_HEX));
        corner_words.push_back(make_word({64{1'b1}}, MODE_UDEC));
        corner_words.push_back(make_word({64{1'b1}}, MODE_SDEC));
        corner_words.push_back(make_word({1'b1, 63'd0}, MODE_SDEC));
        corner_words.push_back(make_word({1'b1, 63'd0}, MODE_UDEC));
        corner_words.push_back(make_word({1'b1, 63'd0}, MODE_HEX));
        corner_words.push_back(make_word({1'b0, {63{1'b1}}}, MODE_SDEC));
        corner_words.push_back(make_word(64'd9, MODE_UDEC));
        corner_words.push_back(make_word(64'd10, MODE_SDEC));
        corner_words.push_back(make_word(64'd15, MODE_HEX));
        corner_words.push_back(make_word(64'd16, MODE_HEX));
        corner_words.push_back(make_word(64'h0123_4567_89AB_CDEF, MODE_HEX));
        corner_words.push_back(make_word(64'd10000000000000000000, MODE_UDEC));
        corner_words.push_back(make_word(64'd9999999999999999999, MODE_UDEC));
        corner_words.push_back(make_word({64{1'b1}}, MODE_DROP));
        corner_words.push_back(make_word(64'd1, MODE_SDEC));
        corner_words.push_back(make_word(64'd0, MODE_DROP));
        corner_words.push_back(make_word(64'hFFFF_FFFF_FFFF_FFF6, MODE_SDEC));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (corner_words[i]) begin
            send_word(corner_words[i]);
            pause_sender($urandom_range(0, 1) ? 0 : $urandom_range(1, 10));
        end
        drain_results();

        // Long receiver hold-off while words keep coming.
        hold_req <= 1'b1;
        repeat (30) begin
            w = make_word(random_value(), 2'(($urandom_range(0, 2))));
            send_word(w);
            sent++;
        end

        while (sent < RANDOM_WORDS) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                w = make_word(random_value(), random_mode());
                send_word(w);
                if (w.mode != MODE_DROP) begin
                    sent++;
                end
            end
            if (!drained && sent >= RANDOM_WORDS / 2) begin
                drained = 1'b1;
                drain_results();
            end else begin
                pause_sender($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 15));
            end
        end

        drain_results();
        repeat (SETTLE) @(posedge aclk);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/itad_pkg.sv
rtl/integer_to_ascii_digits.sv
bench/integer_to_ascii_digits_check.sv
bench/integer_to_ascii_digits_test.sv
